>>> rtl/core/swjf_pkg.sv
// Shared types and constants of the sliding window jet finder.
package swjf_pkg;

  localparam int PHI_GRID_DEF = 72;
  localparam int ETA_GRID_DEF = 18;
  localparam int WIN_PHI_DEF  = 9;
  localparam int WIN_ETA_DEF  = 9;
  localparam int PT_WIDTH_DEF = 16;

  localparam int TOWER_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [7:0] RESTART_PHASE = -8'sd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_MIN     = 2'd0,
    REG_PHASE_PERIOD = 2'd1
  } cfg_reg_t;

  // Control part of one slice command from front to back.
  typedef struct packed {
    logic              restart;
    logic signed [7:0] phase;
  } cmd_ctl_t;

  typedef struct packed {
    logic [15:0] jet_pt;
    logic [6:0]  jet_phi;
    logic [4:0]  jet_eta;
    logic        last_jet;
  } res_t;

endpackage

>>> rtl/core/sliding_window_jet_finder_unit.sv
// Top level of the sliding window jet finder with its configuration registers.
//
// Input channel: one tower per transfer (push/full), in eta order, one phi
// slice after another; last_in_slice closes a slice, req_type=1 restarts the
// ring (window cleared, phase to -2, no results). Each closed slice yields
// exactly ETA_GRID results on the output queue (empty/pop), oldest first,
// with last_jet set on the final one.
// Config: cfg_valid/cfg_ready write channel, always ready; index 0 is
// the seed minimum, index 1 phase_period. Write only while the block is idle.
// Towers inside a slice are taken one per cycle while full is low. The back
// end searches one jet at a time, one tower per cycle within a window row,
// out of a one-row-per-read window memory. Two closed slices queue between
// front and back; when that queue is full, full rises and holds the input.
// A stalled receiver holds the result queue full and the back end waits in
// place; nothing is dropped. Reset clears window, phase, queues and registers;
// the replay store needs no clearing.
module sliding_window_jet_finder_unit #(
  parameter int PHI_GRID = swjf_pkg::PHI_GRID_DEF,
  parameter int ETA_GRID = swjf_pkg::ETA_GRID_DEF,
  parameter int WIN_PHI  = swjf_pkg::WIN_PHI_DEF,
  parameter int WIN_ETA  = swjf_pkg::WIN_ETA_DEF,
  parameter int PT_WIDTH = swjf_pkg::PT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              req_type,
  input  logic [15:0]                       tower_pt,
  input  logic                              last_in_slice,
  output logic                              empty,
  input  logic                              pop,
  output logic [15:0]                       jet_pt,
  output logic [6:0]                        jet_phi,
  output logic [4:0]                        jet_eta,
  output logic                              last_jet,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swjf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swjf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import swjf_pkg::*;

  localparam int RW = ETA_GRID * TOWER_W;
  localparam int CQW = $bits(cmd_ctl_t) + RW;

  logic [15:0]    seed_min;
  logic [6:0]     phase_period;

  logic           f_push;
  cmd_ctl_t       f_ctl;
  logic [RW-1:0]  f_row;
  logic           cq_full;
  logic           cq_empty;
  logic           cq_pop;
  logic [CQW-1:0] cq_head;
  cmd_ctl_t       b_ctl;
  logic [RW-1:0]  b_row;

  logic           rq_full;
  logic           rq_push;
  res_t           rq_in;
  res_t           rq_out;

  // Register file: always ready; writes are registered.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_min     <= '0;
      phase_period <= 7'd80;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEED_MIN:     seed_min     <= cfg_data;
        REG_PHASE_PERIOD: phase_period <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Front: slice assembly and phase tracking.
  swjf_front #(
    .ETA_GRID (ETA_GRID)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .req_type      (req_type),
    .tower_pt      (tower_pt),
    .last_in_slice (last_in_slice),
    .full          (full),
    .phase_period  (phase_period),
    .cq_push       (f_push),
    .cq_ctl        (f_ctl),
    .cq_row        (f_row),
    .cq_full       (cq_full)
  );

  // Slice command queue: lets the front keep loading while jets are searched.
  swjf_fifo #(
    .WIDTH (CQW),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_ctl, f_row}),
    .full      (cq_full),
    .pop       (cq_pop),
    .pop_data  (cq_head),
    .empty     (cq_empty)
  );

  assign b_ctl = cmd_ctl_t'(cq_head[CQW-1 -: $bits(cmd_ctl_t)]);
  assign b_row = cq_head[RW-1:0];

  // Back: window update and jet search.
  swjf_back #(
    .PHI_GRID (PHI_GRID),
    .ETA_GRID (ETA_GRID),
    .WIN_PHI  (WIN_PHI),
    .WIN_ETA  (WIN_ETA),
    .PT_WIDTH (PT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .seed_min (seed_min),
    .cq_empty (cq_empty),
    .cq_ctl   (b_ctl),
    .cq_row   (b_row),
    .cq_pop   (cq_pop),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_data  (rq_in)
  );

  // Result queue: the output register stage toward the receiver.
  swjf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (rq_push),
    .push_data (rq_in),
    .full      (rq_full),
    .pop       (pop),
    .pop_data  (rq_out),
    .empty     (empty)
  );

  assign jet_pt   = rq_out.jet_pt;
  assign jet_phi  = rq_out.jet_phi;
  assign jet_eta  = rq_out.jet_eta;
  assign last_jet = rq_out.last_jet;

endmodule

>>> rtl/core/swjf_fifo.sv
// Small first-word-fall-through queue.
module swjf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt == CW'(DEPTH));
  assign empty    = (cnt == '0);
  assign pop_data = mem[rp];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/swjf_front.sv
// Front end: assembles towers into slices, runs the phase counter.
module swjf_front #(
  parameter int ETA_GRID = swjf_pkg::ETA_GRID_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic                                 req_type,
  input  logic [swjf_pkg::TOWER_W-1:0]         tower_pt,
  input  logic                                 last_in_slice,
  output logic                                 full,
  input  logic [6:0]                           phase_period,
  output logic                                 cq_push,
  output swjf_pkg::cmd_ctl_t                   cq_ctl,
  output logic [ETA_GRID*swjf_pkg::TOWER_W-1:0] cq_row,
  input  logic                                 cq_full
);
  import swjf_pkg::*;

  localparam int EW = $clog2(ETA_GRID);
  localparam int PW = $clog2(ETA_GRID + 1);

  logic [TOWER_W-1:0] incoming_row [ETA_GRID];
  logic [TOWER_W-1:0] row_next     [ETA_GRID];
  logic [PW-1:0]      eta_position;
  logic signed [7:0]  phase_count;
  logic signed [7:0]  phase_next;
  logic               accept;
  logic               pos_ok;

  assign full   = cq_full;
  assign accept = push && !cq_full;
  assign pos_ok = (eta_position < PW'(ETA_GRID));

  always_comb begin
    row_next = incoming_row;
    if (pos_ok) begin
      row_next[eta_position[EW-1:0]] = tower_pt;
    end
    if (int'(phase_count) == int'(phase_period) - 1) begin
      phase_next = '0;
    end else begin
      phase_next = phase_count + 8'sd1;
    end
  end

  always_comb begin
    for (int i = 0; i < ETA_GRID; i++) begin
      cq_row[i*TOWER_W +: TOWER_W] = row_next[i];
    end
    cq_ctl.restart = req_type;
    cq_ctl.phase   = req_type ? RESTART_PHASE : phase_next;
    cq_push        = accept && (req_type || last_in_slice);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eta_position <= '0;
      phase_count  <= '0;
      for (int i = 0; i < ETA_GRID; i++) begin
        incoming_row[i] <= '0;
      end
    end else if (accept) begin
      if (req_type || last_in_slice) begin
        eta_position <= '0;
        phase_count  <= req_type ? RESTART_PHASE : phase_next;
        for (int i = 0; i < ETA_GRID; i++) begin
          incoming_row[i] <= '0;
        end
      end else begin
        incoming_row <= row_next;
        if (pos_ok) begin
          eta_position <= eta_position + 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/swjf_back.sv
// Back end: window and replay memories, jet search, result emission.
module swjf_back #(
  parameter int PHI_GRID = swjf_pkg::PHI_GRID_DEF,
  parameter int ETA_GRID = swjf_pkg::ETA_GRID_DEF,
  parameter int WIN_PHI  = swjf_pkg::WIN_PHI_DEF,
  parameter int WIN_ETA  = swjf_pkg::WIN_ETA_DEF,
  parameter int PT_WIDTH = swjf_pkg::PT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [15:0]                          seed_min,
  input  logic                                 cq_empty,
  input  swjf_pkg::cmd_ctl_t                   cq_ctl,
  input  logic [ETA_GRID*swjf_pkg::TOWER_W-1:0] cq_row,
  output logic                                 cq_pop,
  input  logic                                 rq_full,
  output logic                                 rq_push,
  output swjf_pkg::res_t                       rq_data
);
  import swjf_pkg::*;

  localparam int RW = ETA_GRID * TOWER_W;
  localparam int EW = $clog2(ETA_GRID);
  localparam int WA = $clog2(WIN_PHI);
  localparam int RA = $clog2(WIN_PHI - 1);
  localparam int DW = $clog2(WIN_ETA);
  localparam int PC = WIN_PHI / 2;
  localparam int HE = WIN_ETA / 2;
  localparam int AW = (PT_WIDTH > TOWER_W) ? PT_WIDTH : TOWER_W;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_RD, S_USE, S_EMIT, S_SHIFT} state_t;

  state_t state;

  logic [RW-1:0]       win_mem [WIN_PHI];
  logic [WIN_PHI-1:0]  win_valid;
  logic [RW-1:0]       win_rdata;
  logic                win_rvalid;
  logic [RW-1:0]       rp_mem [WIN_PHI-1];
  logic [RW-1:0]       rp_rdata;

  logic [WA-1:0]       base;
  logic [EW-1:0]       e;
  logic [WA-1:0]       dp;
  logic [DW-1:0]       de;
  logic                centre_ph;
  logic [TOWER_W-1:0]  centre;
  logic                maxi;
  logic [PT_WIDTH-1:0] acc;

  int                  pi;
  logic                keep_rp;
  logic                use_new;
  logic                use_rp;
  logic                null_slot;
  logic [RA-1:0]       rp_waddr;
  logic [RA-1:0]       rp_raddr;
  logic [WA-1:0]       top_addr;
  logic [WA-1:0]       rd_addr;
  logic [RW-1:0]       src_row;
  logic                cmd_slice;
  int                  eta_i;
  int                  diag;
  int                  phi_i;
  logic                in_rng;
  logic [EW-1:0]       sel;
  logic [TOWER_W-1:0]  t;
  logic                is_c;
  logic                strict;
  logic [AW-1:0]       sum_wide;

  function automatic logic [WA-1:0] phys(input logic [WA-1:0] b, input logic [WA-1:0] r);
    logic [WA:0] s;
    s = {1'b0, b} + {1'b0, r};
    if (s >= (WA+1)'(WIN_PHI)) begin
      s = s - (WA+1)'(WIN_PHI);
    end
    return s[WA-1:0];
  endfunction

  always_comb begin
    pi        = int'(cq_ctl.phase);
    keep_rp   = (pi >= 0) && (pi < WIN_PHI - 1);
    use_new   = (pi < PHI_GRID);
    use_rp    = (pi >= PHI_GRID) && (pi < PHI_GRID + WIN_PHI - 1);
    null_slot = (pi < WIN_PHI - 1) || (pi >= PHI_GRID + WIN_PHI - 1);
    rp_waddr  = RA'(pi);
    rp_raddr  = RA'(pi - PHI_GRID);
    top_addr  = phys(base, WA'(WIN_PHI - 1));
    rd_addr   = phys(base, centre_ph ? WA'(PC) : dp);
    cmd_slice = (state == S_IDLE) && !cq_empty && !cq_ctl.restart;
    if (use_new) begin
      src_row = cq_row;
    end else if (use_rp) begin
      src_row = rp_rdata;
    end else begin
      src_row = '0;
    end
  end

  // Tower pick and local maximum rule for the current box position.
  always_comb begin
    eta_i    = centre_ph ? int'(e) : int'(e) + int'(de) - HE;
    in_rng   = (eta_i >= 0) && (eta_i < ETA_GRID);
    sel      = EW'(eta_i);
    t        = (win_rvalid && in_rng) ? win_rdata[sel*TOWER_W +: TOWER_W] : '0;
    diag     = HE - int'(de);
    is_c     = (de == DW'(HE)) && (dp == WA'(PC));
    strict   = (dp > WA'(PC)) ? (int'(dp) >= diag) : (int'(dp) > diag);
    sum_wide = AW'(acc) + AW'(t);
    phi_i    = pi - PC;
    if (phi_i >= PHI_GRID) begin
      phi_i = phi_i - PHI_GRID;
    end
  end

  always_comb begin
    rq_push = (state == S_EMIT) && !rq_full;
    cq_pop  = (state == S_SHIFT) ||
              ((state == S_IDLE) && !cq_empty && cq_ctl.restart);
    if (null_slot) begin
      rq_data.jet_pt  = '0;
      rq_data.jet_phi = '0;
      rq_data.jet_eta = '0;
    end else begin
      rq_data.jet_pt  = maxi ? 16'(acc) : 16'd0;
      rq_data.jet_phi = 7'(phi_i);
      rq_data.jet_eta = 5'(e);
    end
    rq_data.last_jet = (e == EW'(ETA_GRID - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd_slice) begin
      if (keep_rp) begin
        rp_mem[rp_waddr] <= cq_row;
      end
      if (use_rp) begin
        rp_rdata <= rp_mem[rp_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      win_mem[top_addr] <= src_row;
    end
    win_rdata <= win_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      win_valid  <= '0;
      win_rvalid <= 1'b0;
      base       <= '0;
      e          <= '0;
      dp         <= '0;
      de         <= '0;
      centre_ph  <= 1'b1;
      centre     <= '0;
      maxi       <= 1'b0;
      acc        <= '0;
    end else begin
      win_rvalid <= win_valid[rd_addr];
      unique case (state)
        S_IDLE: begin
          if (!cq_empty) begin
            if (cq_ctl.restart) begin
              win_valid <= '0;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          win_valid[top_addr] <= use_new || use_rp;
          e         <= '0;
          centre_ph <= 1'b1;
          state     <= S_RD;
        end
        S_RD: begin
          state <= S_USE;
        end
        S_USE: begin
          if (centre_ph) begin
            centre    <= t;
            maxi      <= (t >= seed_min);
            acc       <= '0;
            centre_ph <= 1'b0;
            dp        <= '0;
            de        <= '0;
            state     <= S_RD;
          end else begin
            acc <= PT_WIDTH'(sum_wide);
            if (!is_c) begin
              if (centre < t) begin
                maxi <= 1'b0;
              end else if (strict && (centre == t)) begin
                maxi <= 1'b0;
              end
            end
            if (de == DW'(WIN_ETA - 1)) begin
              de <= '0;
              if (dp == WA'(WIN_PHI - 1)) begin
                state <= S_EMIT;
              end else begin
                dp    <= dp + 1'b1;
                state <= S_RD;
              end
            end else begin
              de <= de + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!rq_full) begin
            if (e == EW'(ETA_GRID - 1)) begin
              state <= S_SHIFT;
            end else begin
              e         <= e + 1'b1;
              centre_ph <= 1'b1;
              state     <= S_RD;
            end
          end
        end
        S_SHIFT: begin
          win_valid[base] <= 1'b0;
          base  <= (base == WA'(WIN_PHI - 1)) ? '0 : base + 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
